### rtl/vad_pkg.sv
// Shared types, constants and table functions of the vector angle block.
package vad_pkg;

    // Field and datapath widths.
    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int ANG_W           = 9 + ANGLE_FRAC_BITS;
    localparam int DIFF_W          = COORD_BITS + 1;
    localparam int MSB_W           = $clog2(DIFF_W);
    localparam int NORM_MSB        = 59;
    localparam int SHIFT_W         = $clog2(NORM_MSB + 1);
    localparam int XY_W            = NORM_MSB + 4;

    // Rotation unit: step count and angle accumulator format (radians).
    localparam int CORDIC_STEPS = 40;
    localparam int Z_FRAC       = 40;
    localparam int Z_W          = Z_FRAC + 3;

    // The arctangent table is summed at a finer scale and then rounded.
    localparam int TAB_FRAC  = 62;
    localparam int TAB_TERMS = 31;

    // Rational approximation of pi and the radian to degree ratio.
    localparam logic [63:0] PI_NUM  = 64'd1146408;
    localparam logic [63:0] PI_DEN  = 64'd364913;
    localparam logic [63:0] DEG_NUM = 64'd5473695;
    localparam logic [63:0] DEG_DEN = 64'd95534;

    localparam logic [63:0] ATAN_0 =
        ((PI_NUM << Z_FRAC) + 64'd2 * PI_DEN) / (64'd4 * PI_DEN);

    // Quadrant base angles and the full turn, in output units.
    localparam logic [ANG_W-1:0] ANGLE_90  = ANG_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [ANG_W-1:0] ANGLE_180 = ANG_W'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [ANG_W-1:0] ANGLE_270 = ANG_W'(270 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [ANG_W-1:0] ANGLE_360 = ANG_W'(360 * (2 ** ANGLE_FRAC_BITS));

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    // Information that rides alongside the rotation datapath.
    typedef struct packed {
        t_quad quad;
        logic  exact;
        logic  zero;
    } t_side;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] to_x;
        logic signed [COORD_BITS-1:0] to_y;
    } t_in;

    typedef struct packed {
        logic [ANG_W-1:0] angle_deg;
        logic             zero_vector;
    } t_out;

    // One term of the arctangent series: the power of two over the k-th odd number.
    function automatic logic [63:0] odd_div(logic [63:0] p, int k);
        case (k)
            0:       return p;
            1:       return p / 64'd3;
            2:       return p / 64'd5;
            3:       return p / 64'd7;
            4:       return p / 64'd9;
            5:       return p / 64'd11;
            6:       return p / 64'd13;
            7:       return p / 64'd15;
            8:       return p / 64'd17;
            9:       return p / 64'd19;
            10:      return p / 64'd21;
            11:      return p / 64'd23;
            12:      return p / 64'd25;
            13:      return p / 64'd27;
            14:      return p / 64'd29;
            15:      return p / 64'd31;
            16:      return p / 64'd33;
            17:      return p / 64'd35;
            18:      return p / 64'd37;
            19:      return p / 64'd39;
            20:      return p / 64'd41;
            21:      return p / 64'd43;
            22:      return p / 64'd45;
            23:      return p / 64'd47;
            24:      return p / 64'd49;
            25:      return p / 64'd51;
            26:      return p / 64'd53;
            27:      return p / 64'd55;
            28:      return p / 64'd57;
            29:      return p / 64'd59;
            30:      return p / 64'd61;
            default: return '0;
        endcase
    endfunction

    // Arctangent of 2^-i in radians with Z_FRAC fractional bits.
    function automatic logic [Z_W-1:0] atan_entry(int i);
        logic [63:0] s;
        logic [63:0] t;
        int          e;
        s = '0;
        if (i == 0) begin
            return ATAN_0[Z_W-1:0];
        end
        for (int k = 0; k < TAB_TERMS; k++) begin
            e = TAB_FRAC - i * (2 * k + 1);
            if (e >= 0) begin
                t = odd_div(64'd1 << e, k);
                if ((k & 1) != 0) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
        end
        return Z_W'((s + (64'd1 << (TAB_FRAC - Z_FRAC - 1))) >> (TAB_FRAC - Z_FRAC));
    endfunction

    // Base angle of a quadrant.
    function automatic logic [ANG_W-1:0] base_angle(t_quad q);
        unique case (q)
            QUAD_0:   return '0;
            QUAD_90:  return ANGLE_90;
            QUAD_180: return ANGLE_180;
            QUAD_270: return ANGLE_270;
            default:  return '0;
        endcase
    endfunction

endpackage

### rtl/vad_cordic.sv
// Pipelined CORDIC vectoring unit, one rotation step per register stage.
module vad_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  vad_pkg::t_side                      i_side,
    input  logic signed [vad_pkg::XY_W-1:0]     i_x,
    input  logic signed [vad_pkg::XY_W-1:0]     i_y,
    output logic                                o_valid,
    output vad_pkg::t_side                      o_side,
    output logic signed [vad_pkg::Z_W-1:0]      o_z
);

    localparam int STEPS = vad_pkg::CORDIC_STEPS;
    localparam int XY_W  = vad_pkg::XY_W;
    localparam int Z_W   = vad_pkg::Z_W;

    // Stage boundaries: index g is the input of step g.
    logic                   w_valid [STEPS+1];
    vad_pkg::t_side         w_side  [STEPS+1];
    logic signed [XY_W-1:0] w_x     [STEPS];
    logic signed [XY_W-1:0] w_y     [STEPS];
    logic signed [Z_W-1:0]  w_z     [STEPS+1];

    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;
    assign w_x[0]     = i_x;
    assign w_y[0]     = i_y;
    assign w_z[0]     = '0;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic signed [Z_W-1:0] ATAN_STEP = $signed(vad_pkg::atan_entry(g));

        logic                  w_neg;
        logic signed [Z_W-1:0] n_z;
        logic signed [Z_W-1:0] r_z;
        logic                  r_valid;
        vad_pkg::t_side        r_side;

        // The sign of the residual y picks the direction of rotation.
        assign w_neg = w_y[g][XY_W-1];

        always_comb begin
            if (!w_neg) begin
                n_z = w_z[g] + ATAN_STEP;
            end else begin
                n_z = w_z[g] - ATAN_STEP;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z    <= n_z;
                r_side <= w_side[g];
            end
        end

        assign w_valid[g+1] = r_valid;
        assign w_side[g+1]  = r_side;
        assign w_z[g+1]     = r_z;

        // Every step but the last also rotates the vector for the step after it.
        if (g < STEPS - 1) begin : g_xy
            logic signed [XY_W-1:0] w_xs;
            logic signed [XY_W-1:0] w_ys;
            logic signed [XY_W-1:0] n_x;
            logic signed [XY_W-1:0] n_y;
            logic signed [XY_W-1:0] r_x;
            logic signed [XY_W-1:0] r_y;

            assign w_xs = w_x[g] >>> g;
            assign w_ys = w_y[g] >>> g;

            always_comb begin
                if (!w_neg) begin
                    n_x = w_x[g] + w_ys;
                    n_y = w_y[g] - w_xs;
                end else begin
                    n_x = w_x[g] - w_ys;
                    n_y = w_y[g] + w_xs;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x <= n_x;
                    r_y <= n_y;
                end
            end

            assign w_x[g+1] = r_x;
            assign w_y[g+1] = r_y;
        end
    end

    assign o_valid = w_valid[STEPS];
    assign o_side  = w_side[STEPS];
    assign o_z     = w_z[STEPS];

endmodule

### rtl/vad_scale.sv
// Radian to degree conversion, rounding, capping and quadrant offset.
module vad_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  vad_pkg::t_side                  i_side,
    input  logic signed [vad_pkg::Z_W-1:0]  i_z,
    output logic                            o_valid,
    output vad_pkg::t_out                   o_data
);

    localparam int Z_W     = vad_pkg::Z_W;
    localparam int ANG_W   = vad_pkg::ANG_W;
    localparam int ZM_W    = Z_W - 1;
    localparam int ZL      = ZM_W / 2;
    localparam int ZH      = ZM_W - ZL;
    localparam int DN_W    = $clog2(vad_pkg::DEG_NUM + 64'd1);
    localparam int DEN_LOG = $clog2(vad_pkg::DEG_DEN) - 1;
    localparam int DD_W    = DEN_LOG + 1;
    localparam int A_W     = 64;
    localparam int DROP    = vad_pkg::Z_FRAC - vad_pkg::ANGLE_FRAC_BITS;
    localparam int H_W     = A_W - DROP;
    localparam int Q_W     = H_W - DEN_LOG;
    localparam int RECIP_SH = H_W + DEN_LOG;
    localparam int STAGES  = 6;

    localparam logic [DN_W-1:0] DEG_NUM_C = vad_pkg::DEG_NUM[DN_W-1:0];
    localparam logic [DD_W-1:0] DEG_DEN_C = vad_pkg::DEG_DEN[DD_W-1:0];
    localparam logic [A_W-1:0]  ROUND_ADD = vad_pkg::DEG_DEN << (DROP - 1);
    localparam logic [H_W-1:0]  RECIP     = H_W'((64'd1 << RECIP_SH) / vad_pkg::DEG_DEN);

    logic           r_valid [STAGES];
    vad_pkg::t_side r_side  [STAGES-1];

    logic [ZM_W-1:0]       w_zc;
    logic [ZL+DN_W-1:0]    n_a_lo, r_a_lo;
    logic [ZH+DN_W-1:0]    n_a_hi, r_a_hi;
    logic [A_W-1:0]        w_acc;
    logic [H_W-1:0]        r_b_h;
    logic [2*H_W-1:0]      w_prod;
    logic [H_W-1:0]        r_c_h;
    logic [Q_W-1:0]        r_c_q0;
    logic [H_W:0]          n_d_qd, r_d_qd;
    logic [H_W-1:0]        r_d_h;
    logic [Q_W-1:0]        r_d_q0;
    logic [H_W:0]          w_rem;
    logic [Q_W-1:0]        n_e_q, r_e_q;
    logic [ANG_W-1:0]      w_theta;
    logic [ANG_W-1:0]      w_base;
    logic [ANG_W-1:0]      w_sum;
    vad_pkg::t_out         n_f_data, r_f_data;

    // Valid bits and side information advance together with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < STAGES - 1; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Negative angles clamp to zero; the product is split into two halves.
    assign w_zc   = i_z[Z_W-1] ? '0 : i_z[ZM_W-1:0];
    assign n_a_lo = (ZL+DN_W)'(w_zc[ZL-1:0]) * (ZL+DN_W)'(DEG_NUM_C);
    assign n_a_hi = (ZH+DN_W)'(w_zc[ZM_W-1:ZL]) * (ZH+DN_W)'(DEG_NUM_C);

    // Rejoin the halves and fold the rounding into the division by the ratio.
    assign w_acc = (A_W'(r_a_hi) << ZL) + A_W'(r_a_lo) + ROUND_ADD;

    // Quotient estimate by reciprocal; it is exact or one short.
    assign w_prod = (2*H_W)'(r_b_h) * (2*H_W)'(RECIP);

    // Back-multiply the estimate to find the remainder.
    assign n_d_qd = (H_W+1)'(r_c_q0) * (H_W+1)'(DEG_DEN_C);

    // One correction step.
    assign w_rem = (H_W+1)'(r_d_h) - r_d_qd;
    assign n_e_q = (w_rem >= (H_W+1)'(DEG_DEN_C)) ? r_d_q0 + Q_W'(1) : r_d_q0;

    // Cap at a quarter turn, add the quadrant base and wrap a full turn to zero.
    always_comb begin
        w_theta = (ANG_W'(r_e_q) > vad_pkg::ANGLE_90) ? vad_pkg::ANGLE_90 : ANG_W'(r_e_q);
        w_base  = vad_pkg::base_angle(r_side[STAGES-2].quad);
        w_sum   = r_side[STAGES-2].exact ? w_base : w_base + w_theta;
        if (w_sum >= vad_pkg::ANGLE_360) begin
            n_f_data.angle_deg = w_sum - vad_pkg::ANGLE_360;
        end else begin
            n_f_data.angle_deg = w_sum;
        end
        n_f_data.zero_vector = r_side[STAGES-2].zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_lo   <= n_a_lo;
            r_a_hi   <= n_a_hi;
            r_b_h    <= w_acc[A_W-1:DROP];
            r_c_h    <= r_b_h;
            r_c_q0   <= w_prod[2*H_W-1:RECIP_SH];
            r_d_qd   <= n_d_qd;
            r_d_h    <= r_c_h;
            r_d_q0   <= r_c_q0;
            r_e_q    <= n_e_q;
            r_f_data <= n_f_data;
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_data  = r_f_data;

endmodule

### rtl/vector_angle_degrees.sv
// Top level of the vector angle block: front end, rotation unit, scaling and output buffer.
// Takes a start and an end point and returns the direction of the vector between them,
// counter-clockwise from the positive x axis, as degrees times 256 in [0, 360). Vectors on
// an axis give exactly 0, 90, 180 or 270; coincident points give 0 with zero_vector set.
// One word is accepted in every cycle while o_stall is low; each word passes four front-end
// stages (difference, quadrant fold, leading-one search, normalising shift), forty rotation
// stages of the CORDIC pipeline and six stages of degree conversion before the output
// register. A two-entry output buffer lets a word enter while a finished result waits; the
// input stalls only once both entries are full.
module vector_angle_degrees (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vad_pkg::t_in   i_data,
    output logic           o_stall,
    output logic           o_valid,
    output vad_pkg::t_out  o_data,
    input  logic           i_stall
);

    localparam int DIFF_W  = vad_pkg::DIFF_W;
    localparam int MSB_W   = vad_pkg::MSB_W;
    localparam int SHIFT_W = vad_pkg::SHIFT_W;
    localparam int XY_W    = vad_pkg::XY_W;
    localparam int Z_W     = vad_pkg::Z_W;

    logic w_en;

    logic                     r_s1_valid;
    logic signed [DIFF_W-1:0] n_s1_dx, n_s1_dy, r_s1_dx, r_s1_dy;

    logic                     w_negx, w_negy, w_zx, w_zy, w_swap;
    logic [DIFF_W-1:0]        w_ax, w_ay;
    logic                     r_s2_valid;
    logic [DIFF_W-1:0]        n_s2_n, n_s2_d, r_s2_n, r_s2_d;
    vad_pkg::t_side           n_s2_side, r_s2_side;

    logic [DIFF_W-1:0]        w_mx;
    logic                     r_s3_valid;
    logic [MSB_W-1:0]         n_s3_msb, r_s3_msb;
    logic [DIFF_W-1:0]        r_s3_n, r_s3_d;
    vad_pkg::t_side           r_s3_side;

    logic [SHIFT_W-1:0]       w_sh;
    logic                     r_s4_valid;
    logic signed [XY_W-1:0]   n_s4_x, n_s4_y, r_s4_x, r_s4_y;
    vad_pkg::t_side           r_s4_side;

    logic                     w_rot_valid;
    vad_pkg::t_side           w_rot_side;
    logic signed [Z_W-1:0]    w_rot_z;

    logic                     w_res_valid;
    vad_pkg::t_out            w_res_data;

    logic                     r_out_valid;
    vad_pkg::t_out            r_out;
    logic                     r_skid_valid;
    vad_pkg::t_out            r_skid;

    // The whole pipeline advances while the output buffer has room.
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Stage one: vector components.
    assign n_s1_dx = DIFF_W'(i_data.to_x) - DIFF_W'(i_data.from_x);
    assign n_s1_dy = DIFF_W'(i_data.to_y) - DIFF_W'(i_data.from_y);

    // Stage two: magnitudes and quadrant. Off-axis vectors fold into the first quadrant,
    // swapping the roles of the components in the second and fourth quadrants.
    assign w_negx = r_s1_dx[DIFF_W-1];
    assign w_negy = r_s1_dy[DIFF_W-1];
    assign w_zx   = (r_s1_dx == '0);
    assign w_zy   = (r_s1_dy == '0);
    assign w_swap = w_negx ^ w_negy;
    assign w_ax   = w_negx ? DIFF_W'(-r_s1_dx) : DIFF_W'(r_s1_dx);
    assign w_ay   = w_negy ? DIFF_W'(-r_s1_dy) : DIFF_W'(r_s1_dy);

    always_comb begin
        n_s2_side.zero  = w_zx && w_zy;
        n_s2_side.exact = w_zx || w_zy;
        if (w_zy) begin
            n_s2_side.quad = w_negx ? vad_pkg::QUAD_180 : vad_pkg::QUAD_0;
        end else if (w_zx) begin
            n_s2_side.quad = w_negy ? vad_pkg::QUAD_270 : vad_pkg::QUAD_90;
        end else begin
            n_s2_side.quad = vad_pkg::t_quad'({w_negy, w_swap});
        end
        n_s2_n = w_swap ? w_ax : w_ay;
        n_s2_d = w_swap ? w_ay : w_ax;
    end

    // Stage three: position of the leading one of the larger magnitude.
    always_comb begin
        w_mx     = (r_s2_n > r_s2_d) ? r_s2_n : r_s2_d;
        n_s3_msb = '0;
        for (int b = 0; b < DIFF_W; b++) begin
            if (w_mx[b]) begin
                n_s3_msb = MSB_W'(b);
            end
        end
    end

    // Stage four: shift both magnitudes so that the larger tops out at the fixed position.
    assign w_sh   = SHIFT_W'(vad_pkg::NORM_MSB) - SHIFT_W'(r_s3_msb);
    assign n_s4_x = XY_W'(r_s3_d) << w_sh;
    assign n_s4_y = XY_W'(r_s3_n) << w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dx   <= n_s1_dx;
            r_s1_dy   <= n_s1_dy;
            r_s2_n    <= n_s2_n;
            r_s2_d    <= n_s2_d;
            r_s2_side <= n_s2_side;
            r_s3_msb  <= n_s3_msb;
            r_s3_n    <= r_s2_n;
            r_s3_d    <= r_s2_d;
            r_s3_side <= r_s2_side;
            r_s4_x    <= n_s4_x;
            r_s4_y    <= n_s4_y;
            r_s4_side <= r_s3_side;
        end
    end

    vad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_valid),
        .i_side  (r_s4_side),
        .i_x     (r_s4_x),
        .i_y     (r_s4_y),
        .o_valid (w_rot_valid),
        .o_side  (w_rot_side),
        .o_z     (w_rot_z)
    );

    vad_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_valid),
        .i_side  (w_rot_side),
        .i_z     (w_rot_z),
        .o_valid (w_res_valid),
        .o_data  (w_res_data)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= w_res_valid;
            r_out       <= w_res_data;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= w_res_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
